@@ rtl/cdq_pkg.sv @@
// Shared types and constants for the circular deque.
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned IN_W      = 40;
  localparam int unsigned OUT_W     = 72;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_QUERY      = 3'd4
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;   // capture the accepted operation
    logic exec;  // update pointers and write the slot
    logic rd;    // read the front and rear slots
    logic load;  // load the output register
  } cmd_t;

endpackage

@@ rtl/cdq_ctrl.sv @@
// Controller state machine of the circular deque.
module cdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdq_pkg::cmd_t cmd_o
);
  import cdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign load        = (state_q == S_LOAD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o.cap  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec = (state_q == S_EXEC);
    cmd_o.rd   = (state_q == S_READ);
    cmd_o.load = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/cdq_datapath.sv @@
// Datapath of the circular deque: pointers, slot store and output register.
module cdq_datapath #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cdq_pkg::cmd_t               cmd_i,
  input  logic [cdq_pkg::OP_W-1:0]    opcode_i,
  input  logic [cdq_pkg::DATA_W-1:0]  push_value_i,
  output logic [cdq_pkg::ST_W-1:0]    status_o,
  output logic                        is_empty_o,
  output logic                        is_full_o,
  output logic [cdq_pkg::DATA_W-1:0]  front_value_o,
  output logic [cdq_pkg::DATA_W-1:0]  rear_value_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    r = (i == LAST) ? '0 : i + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    r = (i == '0) ? LAST : i - AW'(1);
    return r;
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] val_q;
  logic [AW-1:0]     front_q, front_d, rear_q, rear_d;
  logic              empty_q, empty_d;
  logic [ST_W-1:0]   st_q, st_d;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              full;
  logic [DATA_W-1:0] front_rd_q, rear_rd_q;

  logic [ST_W-1:0]   status_q;
  logic              is_empty_q, is_full_q;
  logic [DATA_W-1:0] front_val_q, rear_val_q;

  assign full = !empty_q && (wrap_next(rear_q) == front_q);

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    empty_d = empty_q;
    st_d    = ST_DONE;
    we      = 1'b0;
    waddr   = '0;
    case (op_q) inside
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full) begin
          st_d = ST_FULL;
        end else if (empty_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
          we      = 1'b1;
        end else if (op_q == OP_PUSH_FRONT) begin
          front_d = wrap_prev(front_q);
          waddr   = wrap_prev(front_q);
          we      = 1'b1;
        end else begin
          rear_d = wrap_next(rear_q);
          waddr  = wrap_next(rear_q);
          we     = 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty_q) begin
          st_d = ST_EMPTY;
        end else if (front_q == rear_q) begin
          empty_d = 1'b1;
          front_d = '0;
          rear_d  = '0;
        end else if (op_q == OP_POP_FRONT) begin
          front_d = wrap_next(front_q);
        end else begin
          rear_d = wrap_prev(rear_q);
        end
      end
      default: ;  // query and unused codes change nothing
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q  <= opcode_i;
      val_q <= push_value_i;
    end
    if (cmd_i.exec) begin
      st_q <= st_d;
    end
  end

  // Slot store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      front_rd_q <= mem[front_q];
      rear_rd_q  <= mem[rear_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q    <= st_q;
      is_empty_q  <= empty_q;
      is_full_q   <= full;
      front_val_q <= empty_q ? '0 : front_rd_q;
      rear_val_q  <= empty_q ? '0 : rear_rd_q;
    end
  end

  assign status_o      = status_q;
  assign is_empty_o    = is_empty_q;
  assign is_full_o     = is_full_q;
  assign front_value_o = front_val_q;
  assign rear_value_o  = rear_val_q;

endmodule

@@ rtl/circular_deque.sv @@
// Top level of the circular deque: controller and datapath.
//
// A double-ended queue of DEPTH signed 32-bit entries held in a circular
// slot store. Operations arrive on the slave stream; each one transfer
// carries an opcode (push front, push rear, pop front, pop rear, query)
// and a push value. For every operation exactly one result transfer leaves
// on the master stream with the status, the empty and full flags, and the
// front and rear entries, which read as zero when the deque is empty.
//
// The transfer captures the operation; the pointer update with slot write,
// the registered read of the front and rear slots and the output load then
// follow in that order. The next operation is accepted as soon as the
// previous result has been loaded, so the block does not take a new
// operation before it is through with the last one. This pace is set by
// the sequencing around the registered read ports of the slot store.
//
// Reset empties the deque and zeroes both pointers; the slot store itself is
// not cleared, since an entry is only reported after its push wrote it. When the
// receiver stalls, the result holds in the output register while the next
// operation is still taken in; that one then waits before its load until
// the pending result has been transferred.
module circular_deque #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tdata: opcode [2:0], push_value [34:3], zero padding [39:35]
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [cdq_pkg::IN_W-1:0]   s_axis_tdata_i,
  // tdata: status [1:0], is_empty [2], is_full [3], front_value [35:4],
  //        rear_value [67:36], zero padding [71:68]
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [cdq_pkg::OUT_W-1:0]  m_axis_tdata_o
);
  import cdq_pkg::*;

  cmd_t              cmd;
  logic [ST_W-1:0]   status;
  logic              is_empty;
  logic              is_full;
  logic [DATA_W-1:0] front_value;
  logic [DATA_W-1:0] rear_value;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (s_axis_tdata_i[OP_W-1:0]),
    .push_value_i  (s_axis_tdata_i[OP_W+DATA_W-1:OP_W]),
    .status_o      (status),
    .is_empty_o    (is_empty),
    .is_full_o     (is_full),
    .front_value_o (front_value),
    .rear_value_o  (rear_value)
  );

  // The result fields are packed from the lowest bit up.
  assign m_axis_tdata_o = {4'b0000, rear_value, front_value, is_full, is_empty, status};

endmodule

@@ rtl/cdq_checker.sv @@
// Port-level checker for the circular deque and its bind statement.
module cdq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_i,
  input logic                      m_axis_tvalid_i,
  input logic                      m_axis_tready_i,
  input logic [cdq_pkg::OUT_W-1:0] m_axis_tdata_i
);
  import cdq_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  // An operation in progress blocks the next one in the cycle after its acceptance.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)
    else $error("input taken while an operation is in progress");

  // The deque is never empty and full at once.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> !(m_axis_tdata_i[2] && m_axis_tdata_i[3]))
    else $error("empty and full both set");

  // An empty deque reports zero at front and rear.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[2] |-> m_axis_tdata_i[67:4] == 64'd0)
    else $error("nonzero values reported for an empty deque");

  // A rejection matches the flag that caused it.
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |->
      (m_axis_tdata_i[1:0] != ST_FULL || m_axis_tdata_i[3]) &&
      (m_axis_tdata_i[1:0] != ST_EMPTY || m_axis_tdata_i[2]))
    else $error("rejection status disagrees with the flags");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

@@ tb/sv/circular_deque_tb.sv @@
// Testbench for the circular deque: directed and random operations checked against a local model.
`timescale 1ns / 100ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int unsigned STALL_PCT  = 38;
  localparam int unsigned RAND_OPS   = 900;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned HANG_LIMIT = 4000;

  // Fields of one result transfer, in the order they sit in tdata (status lowest).
  typedef struct packed {
    logic [DATA_W-1:0] rear_value;
    logic [DATA_W-1:0] front_value;
    logic              is_full;
    logic              is_empty;
    status_e           status;
  } report_t;

  // Mirror of the deque: it applies every accepted operation to its own copy of
  // the store and pointers and queues the report the block has to return.
  class deque_mirror;
    logic [DATA_W-1:0] slots [DEPTH];
    int unsigned       head;
    int unsigned       tail;
    bit                empty;
    report_t           pending_reports [$];
    int unsigned       errors;

    function new();
      head   = 0;
      tail   = 0;
      empty  = 1'b1;
      errors = 0;
    endfunction

    function bit full();
      return !empty && ((tail + 1) % DEPTH == head);
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

    function void apply_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
      report_t rep;
      rep.status = ST_DONE;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (full()) begin
            rep.status = ST_FULL;
          end else if (empty) begin
            // The first entry always lands in slot zero.
            head     = 0;
            tail     = 0;
            slots[0] = value;
            empty    = 1'b0;
          end else if (op == OP_PUSH_FRONT) begin
            head        = (head + DEPTH - 1) % DEPTH;
            slots[head] = value;
          end else begin
            tail        = (tail + 1) % DEPTH;
            slots[tail] = value;
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (empty) begin
            rep.status = ST_EMPTY;
          end else if (head == tail) begin
            empty = 1'b1;
            head  = 0;
            tail  = 0;
          end else if (op == OP_POP_FRONT) begin
            head = (head + 1) % DEPTH;
          end else begin
            tail = (tail + DEPTH - 1) % DEPTH;
          end
        end
        default: ;  // query and the unused codes change nothing
      endcase
      rep.is_empty    = empty;
      rep.is_full     = full();
      rep.front_value = empty ? '0 : slots[head];
      rep.rear_value  = empty ? '0 : slots[tail];
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                logic [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      report_t got;
      report_t want;
      got = data[$bits(report_t)-1:0];
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("is_full", want.is_full, got.is_full);
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("rear_value", want.rear_value, got.rear_value);
    endfunction
  endclass

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i  = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;

  deque_mirror mirror = new();
  bit          stalls_on = 1'b1;
  int unsigned quiet_cycles = 0;

  circular_deque #(.DEPTH(DEPTH)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: drops tready at random, except during the stretch without stalls.
  always @(negedge clk_i) begin
    m_axis_tready_i <= (stalls_on && rst_ni) ? ($urandom_range(99) >= STALL_PCT) : rst_ni;
  end

  // Monitor: results are checked before the same edge's operation is noted,
  // so a result always meets the expectations queued before it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        mirror.check_result(m_axis_tdata_o);
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        mirror.apply_op(s_axis_tdata_i[OP_W-1:0], s_axis_tdata_i[OP_W +: DATA_W]);
      end
    end
  end

  // Watchdog: a run of cycles without any transfer means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("** circular_deque: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sends one operation; random idle cycles come first while stalls are on.
  task automatic issue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    while (stalls_on && $urandom_range(99) < STALL_PCT) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_W - OP_W - DATA_W){1'b0}}, value, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Holds the sender off until every queued report has come back.
  task automatic wait_for_reports();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  // Push values lean on the extremes now and then, otherwise fully random.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned bias;
    int unsigned roll;
    logic [OP_W-1:0] op;

    bias = 50;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Start empty: pops are rejected, query reports zeros.
    issue_op(OP_POP_FRONT, '0);
    issue_op(OP_POP_REAR, '0);
    issue_op(OP_QUERY, 32'hDEAD_BEEF);
    // A single entry, then popping the last entry returns to empty.
    issue_op(OP_PUSH_REAR, 32'h7FFF_FFFF);
    issue_op(OP_POP_REAR, '0);
    issue_op(OP_PUSH_FRONT, 32'h8000_0000);
    issue_op(OP_POP_FRONT, '0);
    // Fill from both ends so the front pointer wraps, then push into a full deque.
    issue_op(OP_PUSH_FRONT, 32'h8000_0000);
    for (int i = 0; i < DEPTH - 1; i++) begin
      issue_op(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, (i == 0) ? 32'hFFFF_FFFF : 32'h1111_1111 * i);
    end
    issue_op(OP_PUSH_FRONT, 32'h5555_5555);
    issue_op(OP_PUSH_REAR, 32'hAAAA_AAAA);
    // Unused opcodes behave as queries.
    issue_op(3'd5, 32'h0000_0001);
    issue_op(3'd6, 32'h0000_0002);
    issue_op(3'd7, 32'h0000_0003);
    issue_op(OP_POP_REAR, '0);
    issue_op(OP_POP_FRONT, '0);
    wait_for_reports();

    // Random part: the push/pop bias swings between filling, draining and
    // balanced phases so the deque keeps crossing both full and empty.
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       bias = 75;
          1:       bias = 25;
          default: bias = 50;
        endcase
      end
      if (n == 450) begin
        wait_for_reports();
      end
      stalls_on = !(n >= 600 && n < 750);
      roll = $urandom_range(99);
      if (roll < 6) begin
        op = 3'($urandom_range(4, 7));
      end else if ($urandom_range(99) < bias) begin
        op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
      end
      issue_op(op, pick_value());
    end
    stalls_on = 1'b1;

    // Drain: wait for the last reports, then watch for strays.
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("** circular_deque: PASSED **");
    end else begin
      $display("** circular_deque: FAILED **");
    end
    $finish;
  end

endmodule
